### rtl/rlz_pkg.sv
// Package for the RLE/LZ byte decompressor: item types, codes and constants.
// Used by every module of the block and by the channel interfaces.
package rlz_pkg;

    // Defaults for the top-level parameters.
    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int OUT_LANES_DEF     = 8;

    // Header byte layout.
    localparam logic [5:0] LEN_MASK = 6'h3F;
    localparam logic [5:0] LEN_EXT  = 6'd63;
    localparam logic [7:0] HDR_END  = 8'h00;

    // Run kinds from the top two bits of a header.
    localparam logic [1:0] KIND_IGNORE  = 2'd0;
    localparam logic [1:0] KIND_REPEAT  = 2'd1;
    localparam logic [1:0] KIND_BACK    = 2'd2;
    localparam logic [1:0] KIND_LITERAL = 2'd3;

    // Results one input item may cause at most.
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXTLEN  = 2'd1,
        PH_OPERAND = 2'd2,
        PH_LITERAL = 2'd3
    } t_phase;

    // Sequencer state.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_PUT,
        ST_FLUSH
    } t_state;

    // Operation of the shared address unit.
    typedef enum logic {
        AOP_INC,
        AOP_SUB
    } t_aop;

    // Input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        out_last;
        logic        stream_end;
        logic [15:0] total_out;
    } t_out_item;

    // Commands from the sequencer to the packer.
    typedef struct packed {
        logic       put;
        logic [7:0] pbyte;
        logic       flush;
        logic       emit;
        logic       last;
        logic       term;
        logic       clr_total;
    } t_pack_cmd;

    // Status from the packer to the sequencer.
    typedef struct packed {
        logic last_lane;
        logic slot_free;
    } t_pack_sts;

endpackage

### rtl/rlz_chan_if.sv
// Valid/ready channel interfaces for the decompressor's input and result items.
// Depends on rlz_pkg for the item types.
interface rlz_in_if ();
    logic              valid;
    logic              ready;
    rlz_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rlz_out_if ();
    logic               valid;
    logic               ready;
    rlz_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/rle_lz_byte_decompressor.sv
// Flow: a header or length item is taken in the idle state; a literal item passes through a put
// state and a flush state to its result. A repeat puts its bytes and flushes whenever the lanes
// fill or the run ends; a back copy needs a history read state before each byte's write state.
// Results leave through a register, so the next item is taken while one waits.
// Reset is synchronous; after it a clearing pass zeroes every history entry before the
// first item is accepted.
module rle_lz_byte_decompressor #(
    parameter int HISTORY_DEPTH = rlz_pkg::HISTORY_DEPTH_DEF,
    parameter int OUT_LANES     = rlz_pkg::OUT_LANES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rlz_in_if.sink    i_in,
    rlz_out_if.source o_out
);
    localparam int PW = $clog2(HISTORY_DEPTH);

    logic               we;
    logic [PW-1:0]      waddr;
    logic [7:0]         wdata;
    logic [PW-1:0]      raddr;
    logic [7:0]         rdata;
    rlz_pkg::t_aop      aop;
    logic [PW-1:0]      abase;
    logic [7:0]         adist;
    logic [PW-1:0]      ares;
    rlz_pkg::t_pack_cmd pack_cmd;
    rlz_pkg::t_pack_sts pack_sts;

    // Parser and sequencer.
    rlz_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_rdata    (rdata),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .o_aop      (aop),
        .o_abase    (abase),
        .o_adist    (adist),
        .i_ares     (ares),
        .o_pack_cmd (pack_cmd),
        .i_pack_sts (pack_sts)
    );

    // Shared pointer and source address arithmetic.
    rlz_addr_unit #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_addr (
        .i_op   (aop),
        .i_base (abase),
        .i_dist (adist),
        .o_res  (ares)
    );

    // History of produced bytes.
    rlz_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Lane packing and result register.
    rlz_packer #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pack_cmd),
        .o_sts   (pack_sts),
        .o_out   (o_out)
    );
endmodule

### rtl/rlz_addr_unit.sv
// Shared address unit: history pointer increment and back-copy source address.
// Depends on rlz_pkg for the operation code.
module rlz_addr_unit #(
    parameter int HISTORY_DEPTH = rlz_pkg::HISTORY_DEPTH_DEF
) (
    input  rlz_pkg::t_aop                      i_op,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]   i_base,
    input  logic [7:0]                         i_dist,
    output logic [$clog2(HISTORY_DEPTH)-1:0]   o_res
);
    localparam int PW = $clog2(HISTORY_DEPTH);

    logic [PW:0] diff;

    // Subtraction with one wrap correction, which is enough only while the distance is below the depth.
    assign diff = {1'b0, i_base} - (PW+1)'(i_dist);

    always_comb begin
        case (i_op)
            rlz_pkg::AOP_SUB: begin
                if (diff[PW]) begin
                    o_res = PW'(diff + (PW+1)'(HISTORY_DEPTH));
                end else begin
                    o_res = PW'(diff);
                end
            end
            default: begin
                if (i_base == PW'(HISTORY_DEPTH - 1)) begin
                    o_res = '0;
                end else begin
                    o_res = PW'(i_base + PW'(1));
                end
            end
        endcase
    end
endmodule

### rtl/rlz_hist_mem.sv
// History memory: one write port and one read port with registered read data.
// Depends on rlz_pkg for the default depth; contents are cleared by the sequencer after reset.
module rlz_hist_mem #(
    parameter int HISTORY_DEPTH = rlz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]   i_waddr,
    input  logic [7:0]                         i_wdata,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]   i_raddr,
    output logic [7:0]                         o_rdata
);
    logic [7:0] r_mem [HISTORY_DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/rlz_packer.sv
// Lane packer and result register with the running output byte count.
// Depends on rlz_pkg and the rlz_out_if interface.
module rlz_packer #(
    parameter int OUT_LANES = rlz_pkg::OUT_LANES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlz_pkg::t_pack_cmd  i_cmd,
    output rlz_pkg::t_pack_sts  o_sts,
    rlz_out_if.source           o_out
);
    localparam int LCW = $clog2(OUT_LANES + 1);
    localparam int LIW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

    logic [OUT_LANES*8-1:0] r_pack_data, n_pack_data;
    logic [LCW-1:0]         r_pack_cnt, n_pack_cnt;
    logic [15:0]            r_total, n_total;
    logic                   r_out_valid, n_out_valid;
    rlz_pkg::t_out_item     r_out, n_out;
    logic [15:0]            sum_total;

    assign sum_total = r_total + 16'(r_pack_cnt);

    // Lane buffer, running count and result register.
    always_comb begin
        n_pack_data = r_pack_data;
        n_pack_cnt  = r_pack_cnt;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.put) begin
            for (int i = 0; i < OUT_LANES; i++) begin
                if (r_pack_cnt[LIW-1:0] == LIW'(i)) begin
                    n_pack_data[i*8 +: 8] = i_cmd.pbyte;
                end
            end
            n_pack_cnt = LCW'(r_pack_cnt + LCW'(1));
        end
        if (i_cmd.flush) begin
            n_pack_data = '0;
            n_pack_cnt  = '0;
            if (i_cmd.emit) begin
                n_total              = sum_total;
                n_out_valid          = 1'b1;
                n_out.out_data       = 64'(r_pack_data);
                n_out.out_count      = 4'(r_pack_cnt);
                n_out.out_last       = i_cmd.last;
                n_out.stream_end     = i_cmd.term;
                n_out.total_out      = sum_total;
            end
        end
        if (i_cmd.clr_total) begin
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_data <= '0;
            r_pack_cnt  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pack_data <= n_pack_data;
            r_pack_cnt  <= n_pack_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Status back to the sequencer.
    assign o_sts.last_lane = (r_pack_cnt == LCW'(OUT_LANES - 1));
    assign o_sts.slot_free = !r_out_valid || o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

### rtl/rlz_ctrl.sv
// Parser and sequencer: decodes headers and drives the history, address unit and packer.
// Depends on rlz_pkg and the rlz_in_if interface.
module rlz_ctrl #(
    parameter int HISTORY_DEPTH = rlz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rlz_in_if.sink                             i_in,
    input  logic [7:0]                         i_rdata,
    output logic                               o_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0]   o_waddr,
    output logic [7:0]                         o_wdata,
    output logic [$clog2(HISTORY_DEPTH)-1:0]   o_raddr,
    output rlz_pkg::t_aop                      o_aop,
    output logic [$clog2(HISTORY_DEPTH)-1:0]   o_abase,
    output logic [7:0]                         o_adist,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]   i_ares,
    output rlz_pkg::t_pack_cmd                 o_pack_cmd,
    input  rlz_pkg::t_pack_sts                 i_pack_sts
);
    localparam int PW = $clog2(HISTORY_DEPTH);

    rlz_pkg::t_state              r_state, n_state;
    rlz_pkg::t_phase              r_phase, n_phase;
    logic [1:0]                   r_kind, n_kind;
    logic [7:0]                   r_rem, n_rem;
    logic [PW-1:0]                r_wp, n_wp;
    logic [7:0]                   r_byte, n_byte;
    logic [7:0]                   r_cnt, n_cnt;
    logic [rlz_pkg::NRES_W-1:0]   r_nres, n_nres;
    logic                         r_back, n_back;
    logic                         r_term, n_term;

    logic                         in_fire;
    logic                         emit;
    logic                         go;
    logic [7:0]                   put_byte;
    rlz_pkg::t_phase              eff_phase;
    logic [1:0]                   eff_kind;
    logic [7:0]                   eff_rem;
    logic [7:0]                   b;

    // Phase that follows a complete length.
    function automatic rlz_pkg::t_phase after_length(input logic [1:0] kind,
                                                     input logic [7:0] len);
        rlz_pkg::t_phase ph;
        case (kind)
            rlz_pkg::KIND_LITERAL: ph = (len != 8'd0) ? rlz_pkg::PH_LITERAL
                                                      : rlz_pkg::PH_HEADER;
            rlz_pkg::KIND_BACK,
            rlz_pkg::KIND_REPEAT:  ph = rlz_pkg::PH_OPERAND;
            default:               ph = rlz_pkg::PH_HEADER;
        endcase
        return ph;
    endfunction

    assign in_fire  = i_in.valid && (r_state == rlz_pkg::ST_IDLE);
    assign b        = i_in.data.in_byte;
    assign emit     = (r_nres != rlz_pkg::NRES_W'(rlz_pkg::MAX_RESULTS));
    assign go       = !emit || i_pack_sts.slot_free;
    assign put_byte = r_back ? i_rdata : r_byte;

    // A stream start puts the parser back to expecting a header first.
    assign eff_phase = i_in.data.stream_start ? rlz_pkg::PH_HEADER : r_phase;
    assign eff_kind  = i_in.data.stream_start ? rlz_pkg::KIND_IGNORE : r_kind;
    assign eff_rem   = i_in.data.stream_start ? 8'd0 : r_rem;

    // Next state and register values.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_wp    = r_wp;
        n_byte  = r_byte;
        n_cnt   = r_cnt;
        n_nres  = r_nres;
        n_back  = r_back;
        n_term  = r_term;
        case (r_state)
            rlz_pkg::ST_CLEAR: begin
                n_wp = i_ares;
                if (r_wp == PW'(HISTORY_DEPTH - 1)) begin
                    n_state = rlz_pkg::ST_IDLE;
                end
            end
            rlz_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_phase = eff_phase;
                    n_kind  = eff_kind;
                    n_rem   = eff_rem;
                    n_nres  = '0;
                    n_term  = 1'b0;
                    n_cnt   = 8'd0;
                    case (eff_phase)
                        rlz_pkg::PH_HEADER: begin
                            if (b == rlz_pkg::HDR_END) begin
                                n_kind  = rlz_pkg::KIND_IGNORE;
                                n_rem   = 8'd0;
                                n_term  = 1'b1;
                                n_back  = 1'b0;
                                n_state = rlz_pkg::ST_FLUSH;
                            end else begin
                                n_kind = b[7:6];
                                if ((b[5:0] & rlz_pkg::LEN_MASK) == rlz_pkg::LEN_EXT) begin
                                    n_phase = rlz_pkg::PH_EXTLEN;
                                end else begin
                                    n_rem   = {2'b00, b[5:0]};
                                    n_phase = after_length(b[7:6], {2'b00, b[5:0]});
                                end
                            end
                        end
                        rlz_pkg::PH_EXTLEN: begin
                            n_rem   = b;
                            n_phase = after_length(eff_kind, b);
                        end
                        rlz_pkg::PH_OPERAND: begin
                            n_byte  = b;
                            n_cnt   = eff_rem;
                            n_rem   = 8'd0;
                            n_phase = rlz_pkg::PH_HEADER;
                            n_back  = (eff_kind == rlz_pkg::KIND_BACK);
                            if (eff_rem != 8'd0) begin
                                n_state = (eff_kind == rlz_pkg::KIND_BACK) ?
                                          rlz_pkg::ST_RD : rlz_pkg::ST_PUT;
                            end
                        end
                        default: begin
                            // Literal byte: one byte out, one fewer left in the run.
                            n_byte  = b;
                            n_cnt   = 8'd1;
                            n_back  = 1'b0;
                            n_state = rlz_pkg::ST_PUT;
                            if (eff_rem != 8'd0) begin
                                n_rem = eff_rem - 8'd1;
                            end
                            if (eff_rem <= 8'd1) begin
                                n_phase = rlz_pkg::PH_HEADER;
                            end
                        end
                    endcase
                end
            end
            rlz_pkg::ST_RD: begin
                n_state = rlz_pkg::ST_PUT;
            end
            rlz_pkg::ST_PUT: begin
                n_wp  = i_ares;
                n_cnt = r_cnt - 8'd1;
                if ((r_cnt == 8'd1) || i_pack_sts.last_lane) begin
                    n_state = rlz_pkg::ST_FLUSH;
                end else if (r_back) begin
                    n_state = rlz_pkg::ST_RD;
                end else begin
                    n_state = rlz_pkg::ST_PUT;
                end
            end
            rlz_pkg::ST_FLUSH: begin
                if (go) begin
                    if (emit) begin
                        n_nres = rlz_pkg::NRES_W'(r_nres + rlz_pkg::NRES_W'(1));
                    end
                    if (r_cnt == 8'd0) begin
                        n_state = rlz_pkg::ST_IDLE;
                    end else if (r_back) begin
                        n_state = rlz_pkg::ST_RD;
                    end else begin
                        n_state = rlz_pkg::ST_PUT;
                    end
                end
            end
            default: begin
                n_state = rlz_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs to the memory, address unit and packer.
    always_comb begin
        i_in.ready = (r_state == rlz_pkg::ST_IDLE);
        o_aop      = (r_state == rlz_pkg::ST_RD) ? rlz_pkg::AOP_SUB : rlz_pkg::AOP_INC;
        o_abase    = r_wp;
        o_adist    = r_byte;
        o_we       = (r_state == rlz_pkg::ST_CLEAR) || (r_state == rlz_pkg::ST_PUT);
        o_waddr    = r_wp;
        o_wdata    = (r_state == rlz_pkg::ST_CLEAR) ? 8'd0 : put_byte;
        o_raddr    = i_ares;
        o_pack_cmd.put       = (r_state == rlz_pkg::ST_PUT);
        o_pack_cmd.pbyte     = put_byte;
        o_pack_cmd.flush     = (r_state == rlz_pkg::ST_FLUSH) && go;
        o_pack_cmd.emit      = emit;
        o_pack_cmd.last      = (r_cnt == 8'd0);
        o_pack_cmd.term      = r_term;
        o_pack_cmd.clr_total = in_fire && i_in.data.stream_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlz_pkg::ST_CLEAR;
            r_phase <= rlz_pkg::PH_HEADER;
            r_kind  <= rlz_pkg::KIND_IGNORE;
            r_rem   <= 8'd0;
            r_wp    <= '0;
            r_cnt   <= 8'd0;
            r_nres  <= '0;
            r_back  <= 1'b0;
            r_term  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_rem   <= n_rem;
            r_wp    <= n_wp;
            r_cnt   <= n_cnt;
            r_nres  <= n_nres;
            r_back  <= n_back;
            r_term  <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

`ifndef SYNTH
    // A byte is only written out while the run still has bytes to give.
    a_put_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlz_pkg::ST_PUT) |-> (r_cnt != 8'd0))
        else $error("byte written with an empty run");

    // The clearing pass leaves the write pointer at the start of the history.
    a_clear_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlz_pkg::ST_CLEAR && r_wp == PW'(HISTORY_DEPTH - 1))
        |=> (r_state == rlz_pkg::ST_IDLE && r_wp == '0))
        else $error("clearing pass did not end at pointer zero");

    // The literal phase always has bytes outstanding.
    a_literal_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rlz_pkg::PH_LITERAL) |-> (r_rem != 8'd0))
        else $error("literal phase with zero length");

    // The result count per item never passes its cap.
    a_nres_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nres == rlz_pkg::NRES_W'(rlz_pkg::MAX_RESULTS))
        |=> ((r_nres == rlz_pkg::NRES_W'(rlz_pkg::MAX_RESULTS)) || (r_nres == '0)))
        else $error("result count passed its cap");
`endif
endmodule

### test/testbench.sv
// Self-checking testbench for the RLE/LZ byte decompressor: directed and random streams.
// Depends on rlz_pkg, the channel interfaces in rlz_chan_if and the top-level RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int LANES     = rlz_pkg::OUT_LANES_DEF;
    localparam int HIST_SIZE = rlz_pkg::HISTORY_DEPTH_DEF;

    // One pending input item, with a flag that holds it back until all results are in.
    typedef struct packed {
        rlz_pkg::t_in_item it;
        logic              drain;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rlz_in_if  in_ch ();
    rlz_out_if out_ch ();

    rle_lz_byte_decompressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Items waiting to be sent and results waiting to arrive.
    t_stim              send_q[$];
    rlz_pkg::t_out_item want_q[$];

    // Decoder state as predicted.
    rlz_pkg::t_phase dec_phase  = rlz_pkg::PH_HEADER;
    logic [1:0]      dec_kind   = rlz_pkg::KIND_IGNORE;
    logic [7:0]      dec_left   = 8'd0;
    logic [7:0]      hist_mem [HIST_SIZE] = '{default: 8'd0};
    logic [7:0]      hist_wr    = 8'd0;
    logic [15:0]     byte_total = 16'd0;

    int  err_count  = 0;
    bit  in_busy    = 1'b0;
    bit  in_taken   = 1'b0;
    bit  calm       = 1'b0;
    int  send_gap   = 0;
    int  stall_left = 0;

    // Clock.
    always #1 i_clk = ~i_clk;

    // Reports one mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Gap or stall length: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Phase that follows once the run length is known.
    task automatic phase_after_length();
        if (dec_kind == rlz_pkg::KIND_LITERAL) begin
            dec_phase = (dec_left != 8'd0) ? rlz_pkg::PH_LITERAL : rlz_pkg::PH_HEADER;
        end else if (dec_kind == rlz_pkg::KIND_BACK || dec_kind == rlz_pkg::KIND_REPEAT) begin
            dec_phase = rlz_pkg::PH_OPERAND;
        end else begin
            dec_phase = rlz_pkg::PH_HEADER;
        end
    endtask

    // Decodes one accepted byte and queues the results it causes.
    task automatic decode_byte(input rlz_pkg::t_in_item it);
        logic [7:0]         b;
        logic [7:0]         run_bytes[$];
        logic [7:0]         v;
        rlz_pkg::t_out_item r;
        int                 k;
        int                 pos;
        int                 cnt;
        b = it.in_byte;
        run_bytes = {};
        if (it.stream_start) begin
            dec_phase  = rlz_pkg::PH_HEADER;
            dec_kind   = rlz_pkg::KIND_IGNORE;
            dec_left   = 8'd0;
            byte_total = 16'd0;
        end
        case (dec_phase)
            rlz_pkg::PH_HEADER: begin
                if (b == rlz_pkg::HDR_END) begin
                    dec_kind     = rlz_pkg::KIND_IGNORE;
                    dec_left     = 8'd0;
                    r            = '0;
                    r.out_last   = 1'b1;
                    r.stream_end = 1'b1;
                    r.total_out  = byte_total;
                    want_q.push_back(r);
                    return;
                end
                dec_kind = b[7:6];
                if (b[5:0] == rlz_pkg::LEN_EXT) begin
                    dec_phase = rlz_pkg::PH_EXTLEN;
                    return;
                end
                dec_left = {2'b00, b[5:0]};
                phase_after_length();
                return;
            end
            rlz_pkg::PH_EXTLEN: begin
                dec_left = b;
                phase_after_length();
                return;
            end
            rlz_pkg::PH_OPERAND: begin
                // A back copy reads byte by byte so that overlapping copies repeat.
                for (k = 0; k < dec_left; k++) begin
                    v = (dec_kind == rlz_pkg::KIND_REPEAT) ? b : hist_mem[hist_wr - b];
                    hist_mem[hist_wr] = v;
                    hist_wr++;
                    run_bytes.push_back(v);
                end
                dec_left  = 8'd0;
                dec_phase = rlz_pkg::PH_HEADER;
            end
            default: begin
                hist_mem[hist_wr] = b;
                hist_wr++;
                run_bytes.push_back(b);
                if (dec_left != 8'd0) begin
                    dec_left--;
                end
                if (dec_left == 8'd0) begin
                    dec_phase = rlz_pkg::PH_HEADER;
                end
            end
        endcase
        // Pack the run into results of up to LANES bytes.
        pos = 0;
        while (pos < run_bytes.size()) begin
            r   = '0;
            cnt = 0;
            while (cnt < LANES && pos < run_bytes.size()) begin
                r.out_data[8*cnt +: 8] = run_bytes[pos];
                cnt++;
                pos++;
            end
            byte_total  = byte_total + cnt[15:0];
            r.out_count = cnt[3:0];
            r.out_last  = (pos >= run_bytes.size());
            r.total_out = byte_total;
            want_q.push_back(r);
        end
    endtask

    // Queues one input item.
    task automatic push_byte(input logic [7:0] b, input logic start, input logic drain);
        t_stim s;
        s.it.in_byte      = b;
        s.it.stream_start = start;
        s.drain           = drain;
        send_q.push_back(s);
    endtask

    // Run length: mostly small, a few large, some at the maximum.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 0;
        end else if (r < 82) begin
            return $urandom_range(1, 12);
        end else if (r < 96) begin
            return $urandom_range(13, 80);
        end else if (r < 98) begin
            return 255;
        end
        return $urandom_range(81, 254);
    endfunction

    // Header for a run, in extended form where the length needs it or at random.
    task automatic push_header(input logic [1:0] kind, input int len, input logic start,
                               input logic drain);
        if (len >= 63 || $urandom_range(0, 19) == 0) begin
            push_byte({kind, rlz_pkg::LEN_EXT}, start, drain);
            push_byte(len[7:0], 1'b0, 1'b0);
        end else begin
            push_byte({kind, len[5:0]}, start, drain);
        end
    endtask

    // A well-formed stream of random runs.
    task automatic push_stream(input int n_runs);
        int   k;
        int   j;
        int   len;
        int   op;
        logic start;
        logic drain;
        for (k = 0; k < n_runs; k++) begin
            start = (k == 0) && ($urandom_range(0, 4) != 0);
            drain = (k == 0) && ($urandom_range(0, 9) == 0);
            op    = $urandom_range(0, 99);
            len   = pick_len();
            if (op < 40) begin
                push_header(rlz_pkg::KIND_LITERAL, len, start, drain);
                for (j = 0; j < len; j++) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end else if (op < 65) begin
                push_header(rlz_pkg::KIND_REPEAT, len, start, drain);
                push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (op < 93) begin
                push_header(rlz_pkg::KIND_BACK, len, start, drain);
                if ($urandom_range(0, 1) == 0) begin
                    push_byte(8'($urandom_range(1, 8)), 1'b0, 1'b0);
                end else begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end else begin
                // Ignored run; its length must not be zero or it would end the stream.
                push_header(rlz_pkg::KIND_IGNORE, (len == 0) ? 1 : len, start, drain);
            end
        end
        if ($urandom_range(0, 9) < 7) begin
            push_byte(rlz_pkg::HDR_END, 1'b0, 1'b0);
        end
    endtask

    // Stimulus and end of the run.
    initial begin
        int k;
        int n;
        i_rst_n = 1'b0;

        // Back copy reaching before the start of output.
        push_byte(8'h88, 1'b1, 1'b0);
        push_byte(8'hC8, 1'b0, 1'b0);
        // Literals with extreme values.
        push_byte(8'hC2, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        // Repeat, short and at the maximum length.
        push_byte(8'h45, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b0);
        // Overlapping back copy at distance one.
        push_byte(8'h8A, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        // Back copy at distance zero and at the largest distance.
        push_byte(8'hBF, 1'b0, 1'b0);
        push_byte(8'h40, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h83, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        // Zero-length literal and zero-length back copy.
        push_byte(8'hC0, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b0);
        // Ignored runs, plain and with an extended length.
        push_byte(8'h15, 1'b0, 1'b0);
        push_byte(8'h3F, 1'b0, 1'b0);
        push_byte(8'h77, 1'b0, 1'b0);
        // Terminator, sent only once all earlier results are in.
        push_byte(rlz_pkg::HDR_END, 1'b0, 1'b1);
        // Continuation after the terminator.
        push_byte(8'hC1, 1'b0, 1'b0);
        push_byte(8'h81, 1'b0, 1'b0);
        // A new stream that cuts a literal run short.
        push_byte(8'hC5, 1'b0, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0);
        push_byte(8'hC1, 1'b1, 1'b0);
        push_byte(8'h22, 1'b0, 1'b0);

        // Random part: mostly well-formed streams, some noise.
        n = send_q.size();
        while (send_q.size() < n + 250) begin
            if ($urandom_range(0, 99) < 85) begin
                push_stream($urandom_range(1, 8));
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                              1'b0);
                end
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (send_q.size() != 0 || in_busy) begin
            @(posedge i_clk);
        end
        while (want_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (600) @(posedge i_clk);
        if (err_count == 0 && want_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #10000000;
        $display("testbench: done, errors");
        $finish;
    end

    // Sampling at the rising edge: predict accepted items, check accepted results.
    always @(posedge i_clk) begin
        rlz_pkg::t_out_item got;
        rlz_pkg::t_out_item exp_r;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data);
                in_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (want_q.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: data %h count %0d",
                                              got.out_data, got.out_count));
                end else begin
                    exp_r = want_q.pop_front();
                    if (got.out_data !== exp_r.out_data) begin
                        report_mismatch($sformatf("out_data %h, expected %h",
                                                  got.out_data, exp_r.out_data));
                    end
                    if (got.out_count !== exp_r.out_count) begin
                        report_mismatch($sformatf("out_count %0d, expected %0d",
                                                  got.out_count, exp_r.out_count));
                    end
                    if (got.out_last !== exp_r.out_last) begin
                        report_mismatch($sformatf("out_last %b, expected %b",
                                                  got.out_last, exp_r.out_last));
                    end
                    if (got.stream_end !== exp_r.stream_end) begin
                        report_mismatch($sformatf("stream_end %b, expected %b",
                                                  got.stream_end, exp_r.stream_end));
                    end
                    if (got.total_out !== exp_r.total_out) begin
                        report_mismatch($sformatf("total_out %0d, expected %0d",
                                                  got.total_out, exp_r.total_out));
                    end
                end
            end
        end
    end

    // Driving at the falling edge: input items with gaps, result stalls.
    always @(negedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.data   <= '0;
            out_ch.ready <= 1'b0;
        end else begin
            // Now and then switch between a calm stretch and an idling one.
            if ($urandom_range(0, 63) == 0) begin
                calm = !calm;
            end

            // Input side.
            if (in_busy && in_taken) begin
                in_busy = 1'b0;
            end
            in_taken = 1'b0;
            if (!in_busy) begin
                if (send_gap > 0 && !calm) begin
                    send_gap--;
                end else if (send_q.size() != 0 &&
                             (!send_q[0].drain || want_q.size() == 0)) begin
                    in_ch.data <= send_q[0].it;
                    void'(send_q.pop_front());
                    in_busy  = 1'b1;
                    send_gap = pick_gap();
                end
            end
            in_ch.valid <= in_busy;

            // Result side.
            if (stall_left > 0 && !calm) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
            out_ch.ready <= rdy;
        end
    end

endmodule
